>>> src/palette_indexer_ntsc_composite_defines.svh
// Assertion macros shared by the palette indexer RTL.
`ifndef PALETTE_INDEXER_NTSC_COMPOSITE_DEFINES_SVH
`define PALETTE_INDEXER_NTSC_COMPOSITE_DEFINES_SVH

// Same-cycle implication on the local clock/reset.
`define PIC_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication on the local clock/reset.
`define PIC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/pic_pkg.sv
// Types, constants and micro-op tables for the palette indexer.
package pic_pkg;

   // Payloads
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       first_pixel;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] index;
      logic       is_new;
      logic       full_error;
      logic [7:0] sample0;
      logic [7:0] sample1;
      logic [7:0] sample2;
      logic [7:0] sample3;
   } rsp_payload_type;

   // CSR map
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLACK_DAC = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DAC   = 1'd1;
   localparam logic [7:0] BLACK_DAC_RESET = 8'd70;
   localparam logic [7:0] MAX_DAC_RESET   = 8'd255;

   // Q14 arithmetic
   localparam int DATA_W = 18;
   localparam int PROD_W = 36;
   localparam int ACC_W  = 40;

   localparam logic signed [DATA_W-1:0] K_YR   = 18'sd4915;
   localparam logic signed [DATA_W-1:0] K_YG   = 18'sd9667;
   localparam logic signed [DATA_W-1:0] K_YB   = 18'sd1802;
   localparam logic signed [DATA_W-1:0] K_IB   = -18'sd4424;
   localparam logic signed [DATA_W-1:0] K_IR   = 18'sd12124;
   localparam logic signed [DATA_W-1:0] K_QB   = 18'sd6717;
   localparam logic signed [DATA_W-1:0] K_QR   = 18'sd7864;
   localparam logic signed [DATA_W-1:0] K_SIN  = 18'sd8923;
   localparam logic signed [DATA_W-1:0] K_COS  = 18'sd13741;
   localparam logic signed [DATA_W-1:0] K_NSIN = -18'sd8923;
   localparam logic signed [DATA_W-1:0] K_NCOS = -18'sd13741;
   localparam logic signed [DATA_W-1:0] Q_ONE  = 18'sd16384;
   localparam logic signed [DATA_W-1:0] Q_NEG_ONE = -18'sd16384;

   // 8-bit component to Q14, round(v * 16384 / 255), built at elaboration
   typedef logic [14:0] q14_tab_type [256];

   function automatic q14_tab_type q14_build();
      q14_tab_type t;
      for (int v = 0; v < 256; v++) begin
         t[v] = 15'((v * 32768 + 255) / 510);
      end
      return t;
   endfunction

   localparam q14_tab_type Q14_TAB = q14_build();

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_YIQ,
      ST_PHASE,
      ST_DONE
   } ctrl_state_type;

   // Micro-op fields for the shared multiply-accumulate
   typedef enum logic [1:0] {
      MAC_NONE,
      MAC_LOAD,
      MAC_ACC,
      MAC_BIAS
   } mac_op_type;

   typedef enum logic [2:0] {
      A_RQ,
      A_GQ,
      A_BQ,
      A_DR,
      A_DB,
      A_I,
      A_Q,
      A_SIG
   } a_sel_type;

   typedef enum logic [3:0] {
      B_YR,
      B_YG,
      B_YB,
      B_IB,
      B_IR,
      B_QB,
      B_QR,
      B_SIN,
      B_COS,
      B_NSIN,
      B_NCOS,
      B_DIFF
   } b_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_Y,
      WR_I,
      WR_Q,
      WR_SIG,
      WR_SMP
   } wr_op_type;

   typedef struct packed {
      mac_op_type mac;
      a_sel_type  asel;
      b_sel_type  bsel;
      wr_op_type  wr;
      logic [1:0] lane;
   } uop_type;

   localparam uop_type UOP_NOP = '{mac: MAC_NONE, asel: A_RQ, bsel: B_YR,
                                   wr: WR_NONE, lane: 2'd0};

   localparam logic [3:0] YIQ_LAST = 4'd8;
   localparam logic [2:0] SUB_LAST = 3'd4;
   localparam logic [1:0] PHASE_LAST = 2'd3;

   function automatic uop_type mk_uop(mac_op_type mac, a_sel_type asel,
                                      b_sel_type bsel, wr_op_type wr,
                                      logic [1:0] lane);
      uop_type u;
      u.mac  = mac;
      u.asel = asel;
      u.bsel = bsel;
      u.wr   = wr;
      u.lane = lane;
      return u;
   endfunction

   // Y, then I and Q from (B-Y), (R-Y)
   function automatic uop_type yiq_uop(logic [3:0] step);
      uop_type u;
      unique case (step)
         4'd0:    u = mk_uop(MAC_LOAD, A_RQ, B_YR, WR_NONE, 2'd0);
         4'd1:    u = mk_uop(MAC_ACC,  A_GQ, B_YG, WR_NONE, 2'd0);
         4'd2:    u = mk_uop(MAC_ACC,  A_BQ, B_YB, WR_NONE, 2'd0);
         4'd3:    u = mk_uop(MAC_NONE, A_RQ, B_YR, WR_Y,    2'd0);
         4'd4:    u = mk_uop(MAC_LOAD, A_DB, B_IB, WR_NONE, 2'd0);
         4'd5:    u = mk_uop(MAC_ACC,  A_DR, B_IR, WR_NONE, 2'd0);
         4'd6:    u = mk_uop(MAC_LOAD, A_DB, B_QB, WR_I,    2'd0);
         4'd7:    u = mk_uop(MAC_ACC,  A_DR, B_QR, WR_NONE, 2'd0);
         4'd8:    u = mk_uop(MAC_NONE, A_RQ, B_YR, WR_Q,    2'd0);
         default: u = UOP_NOP;
      endcase
      return u;
   endfunction

   // One subcarrier phase: Q*sn + I*cs, clamp, scale, saturate
   function automatic uop_type phase_uop(logic [1:0] phase, logic [2:0] sub);
      uop_type   u;
      b_sel_type sn;
      b_sel_type cs;
      unique case (phase)
         2'd0: begin sn = B_SIN;  cs = B_COS;  end
         2'd1: begin sn = B_COS;  cs = B_NSIN; end
         2'd2: begin sn = B_NSIN; cs = B_NCOS; end
         2'd3: begin sn = B_NCOS; cs = B_SIN;  end
      endcase
      unique case (sub)
         3'd0:    u = mk_uop(MAC_LOAD, A_Q,   sn,     WR_NONE, phase);
         3'd1:    u = mk_uop(MAC_ACC,  A_I,   cs,     WR_NONE, phase);
         3'd2:    u = mk_uop(MAC_NONE, A_RQ,  B_YR,   WR_SIG,  phase);
         3'd3:    u = mk_uop(MAC_BIAS, A_SIG, B_DIFF, WR_NONE, phase);
         3'd4:    u = mk_uop(MAC_NONE, A_RQ,  B_YR,   WR_SMP,  phase);
         default: u = UOP_NOP;
      endcase
      return u;
   endfunction

   // Controller to datapath
   typedef struct packed {
      logic    start;
      logic    scan;
      logic    take_hit;
      logic    miss;
      logic    load_rsp;
      uop_type uop;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic hit;
      logic scan_end;
      logic full;
   } dp_status_type;

endpackage

>>> src/pic_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pic_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 254
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/pic_dp.sv
// Datapath: palette scan, entry append, shared Q14 MAC and result register.
`include "palette_indexer_ntsc_composite_defines.svh"

module pic_dp #(
   parameter int PALETTE_ENTRIES = 254
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pic_pkg::dp_cmd_type      cmd,
   output pic_pkg::dp_status_type   status,
   input  pic_pkg::req_payload_type req_payload,
   input  logic [7:0]               black_dac,
   input  logic [7:0]               max_dac,
   output pic_pkg::rsp_payload_type rsp_payload
);

   localparam int CNT_W  = $clog2(PALETTE_ENTRIES + 1);
   localparam int ADDR_W = $clog2(PALETTE_ENTRIES);
   localparam int DW     = pic_pkg::DATA_W;
   localparam int AW     = pic_pkg::ACC_W;

   // scan state
   logic [23:0]       color_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff;
   logic              issue;
   logic              full;
   logic [23:0]       rd_color;
   logic              app_en;

   // arithmetic state
   logic [14:0]          rq_ff, gq_ff, bq_ff;
   logic signed [DW-1:0] y_ff, i_ff, q_ff, sig_ff;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [DW-1:0] a_val, b_val;
   logic signed [pic_pkg::PROD_W-1:0] prod;
   logic signed [DW-1:0] dr, db;
   logic signed [8:0]    diff;
   logic signed [AW-1:0] rnd_sum;
   logic signed [DW-1:0] rnd_val;
   logic signed [DW:0]   sig_sum;
   logic signed [DW-1:0] sig_clamp;
   logic [7:0]           smp_val;

   // working result
   logic [7:0] res_index_ff;
   logic       res_new_ff, res_full_ff;
   logic [7:0] sample_ff [4];
   pic_pkg::rsp_payload_type rsp_ff;

   assign full   = (count_ff == CNT_W'(PALETTE_ENTRIES));
   assign issue  = cmd.scan && (ptr_ff < count_ff);
   assign app_en = cmd.miss && !full;

   assign status.hit      = pend_ff && (rd_color == color_ff);
   assign status.scan_end = !pend_ff && (ptr_ff >= count_ff);
   assign status.full     = full;

   pic_ram #(
      .WIDTH (24),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (app_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (color_ff),
      .rd_en   (issue),
      .rd_addr (ptr_ff[ADDR_W-1:0]),
      .rd_data (rd_color)
   );

   // entry count, scan pointer
   always_comb begin
      count_in = count_ff;
      ptr_in   = ptr_ff;
      pend_in  = pend_ff;
      if (cmd.start) begin
         if (req_payload.first_pixel) begin
            count_in = '0;
         end
         ptr_in  = '0;
         pend_in = 1'b0;
      end else if (cmd.scan) begin
         pend_in = issue;
         if (issue) begin
            ptr_in = ptr_ff + CNT_W'(1);
         end
      end
      // miss is raised inside the scan state, so append is checked on its own
      if (app_en) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
         ptr_ff   <= '0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
         ptr_ff   <= ptr_in;
      end
   end

   // shared multiplier operands
   assign dr   = $signed({3'b000, rq_ff}) - y_ff;
   assign db   = $signed({3'b000, bq_ff}) - y_ff;
   assign diff = $signed({1'b0, max_dac}) - $signed({1'b0, black_dac});

   always_comb begin
      unique case (cmd.uop.asel)
         pic_pkg::A_RQ:  a_val = $signed({3'b000, rq_ff});
         pic_pkg::A_GQ:  a_val = $signed({3'b000, gq_ff});
         pic_pkg::A_BQ:  a_val = $signed({3'b000, bq_ff});
         pic_pkg::A_DR:  a_val = dr;
         pic_pkg::A_DB:  a_val = db;
         pic_pkg::A_I:   a_val = i_ff;
         pic_pkg::A_Q:   a_val = q_ff;
         pic_pkg::A_SIG: a_val = sig_ff;
         default:        a_val = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.uop.bsel)
         pic_pkg::B_YR:   b_val = pic_pkg::K_YR;
         pic_pkg::B_YG:   b_val = pic_pkg::K_YG;
         pic_pkg::B_YB:   b_val = pic_pkg::K_YB;
         pic_pkg::B_IB:   b_val = pic_pkg::K_IB;
         pic_pkg::B_IR:   b_val = pic_pkg::K_IR;
         pic_pkg::B_QB:   b_val = pic_pkg::K_QB;
         pic_pkg::B_QR:   b_val = pic_pkg::K_QR;
         pic_pkg::B_SIN:  b_val = pic_pkg::K_SIN;
         pic_pkg::B_COS:  b_val = pic_pkg::K_COS;
         pic_pkg::B_NSIN: b_val = pic_pkg::K_NSIN;
         pic_pkg::B_NCOS: b_val = pic_pkg::K_NCOS;
         pic_pkg::B_DIFF: b_val = DW'(diff);
         default:         b_val = '0;
      endcase
   end

   assign prod = a_val * b_val;

   always_comb begin
      unique case (cmd.uop.mac)
         pic_pkg::MAC_NONE: acc_in = acc_ff;
         pic_pkg::MAC_LOAD: acc_in = AW'(prod);
         pic_pkg::MAC_ACC:  acc_in = acc_ff + AW'(prod);
         pic_pkg::MAC_BIAS: acc_in = $signed({18'b0, black_dac, 14'b0}) + AW'(prod);
         default:           acc_in = acc_ff;
      endcase
   end

   // round half up at bit 14
   assign rnd_sum = acc_ff + AW'(8192);
   assign rnd_val = $signed(rnd_sum[31:14]);

   // composite level, clamped to +-1.0
   assign sig_sum = (DW+1)'(y_ff) + (DW+1)'(rnd_val);
   always_comb begin
      priority if (sig_sum > (DW+1)'(pic_pkg::Q_ONE)) begin
         sig_clamp = pic_pkg::Q_ONE;
      end else if (sig_sum < (DW+1)'(pic_pkg::Q_NEG_ONE)) begin
         sig_clamp = pic_pkg::Q_NEG_ONE;
      end else begin
         sig_clamp = DW'(sig_sum);
      end
   end

   // DAC code: negative to 0, above 255 saturates
   always_comb begin
      priority if (acc_ff[AW-1]) begin
         smp_val = 8'd0;
      end else if (|acc_ff[AW-2:22]) begin
         smp_val = 8'd255;
      end else begin
         smp_val = acc_ff[21:14];
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.start) begin
         color_ff     <= {req_payload.red, req_payload.green, req_payload.blue};
         rq_ff        <= pic_pkg::Q14_TAB[req_payload.red];
         gq_ff        <= pic_pkg::Q14_TAB[req_payload.green];
         bq_ff        <= pic_pkg::Q14_TAB[req_payload.blue];
         res_index_ff <= 8'd0;
         res_new_ff   <= 1'b0;
         res_full_ff  <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            sample_ff[k] <= 8'd0;
         end
      end
      if (issue) begin
         pend_addr_ff <= ptr_ff[ADDR_W-1:0];
      end
      if (cmd.take_hit) begin
         res_index_ff <= 8'(pend_addr_ff);
      end
      if (cmd.miss) begin
         if (full) begin
            res_full_ff <= 1'b1;
         end else begin
            res_new_ff   <= 1'b1;
            res_index_ff <= 8'(count_ff);
         end
      end
      unique case (cmd.uop.wr)
         pic_pkg::WR_NONE: ;
         pic_pkg::WR_Y:    y_ff <= rnd_val;
         pic_pkg::WR_I:    i_ff <= rnd_val;
         pic_pkg::WR_Q:    q_ff <= rnd_val;
         pic_pkg::WR_SIG:  sig_ff <= sig_clamp;
         pic_pkg::WR_SMP:  sample_ff[cmd.uop.lane] <= smp_val;
         default: ;
      endcase
      if (cmd.load_rsp) begin
         rsp_ff.index      <= res_index_ff;
         rsp_ff.is_new     <= res_new_ff;
         rsp_ff.full_error <= res_full_ff;
         rsp_ff.sample0    <= sample_ff[0];
         rsp_ff.sample1    <= sample_ff[1];
         rsp_ff.sample2    <= sample_ff[2];
         rsp_ff.sample3    <= sample_ff[3];
      end
   end

   assign rsp_payload = rsp_ff;

   `PIC_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(PALETTE_ENTRIES), "entry count past palette size")
   `PIC_ASSERT_NOW(a_ptr_bound, 1'b1, ptr_ff <= count_ff, "scan pointer past entry count")
   `PIC_ASSERT_NOW(a_miss_no_pend, cmd.miss, !pend_ff && ptr_ff == count_ff, "miss taken with compare in flight")

endmodule

>>> src/pic_ctrl.sv
// Controller: sequences accept, palette scan, YIQ/phase micro-ops and result load.
`include "palette_indexer_ntsc_composite_defines.svh"

module pic_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pic_pkg::dp_cmd_type    cmd,
   input  pic_pkg::dp_status_type status
);

   pic_pkg::ctrl_state_type state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic [1:0] phase_ff, phase_in;
   logic [2:0] sub_ff, sub_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pic_pkg::ST_IDLE;
         step_ff      <= '0;
         phase_ff     <= '0;
         sub_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         sub_ff       <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      sub_in       = sub_ff;
      cmd          = '0;
      cmd.uop      = pic_pkg::UOP_NOP;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         pic_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = pic_pkg::ST_SCAN;
            end
         end
         pic_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            priority if (status.hit) begin
               cmd.take_hit = 1'b1;
               state_in     = pic_pkg::ST_DONE;
            end else if (status.scan_end) begin
               cmd.miss = 1'b1;
               step_in  = '0;
               state_in = status.full ? pic_pkg::ST_DONE : pic_pkg::ST_YIQ;
            end else begin
               state_in = pic_pkg::ST_SCAN;
            end
         end
         pic_pkg::ST_YIQ: begin
            cmd.uop = pic_pkg::yiq_uop(step_ff);
            if (step_ff == pic_pkg::YIQ_LAST) begin
               phase_in = '0;
               sub_in   = '0;
               state_in = pic_pkg::ST_PHASE;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         pic_pkg::ST_PHASE: begin
            cmd.uop = pic_pkg::phase_uop(phase_ff, sub_ff);
            if (sub_ff == pic_pkg::SUB_LAST) begin
               sub_in   = '0;
               phase_in = phase_ff + 2'd1;
               if (phase_ff == pic_pkg::PHASE_LAST) begin
                  state_in = pic_pkg::ST_DONE;
               end
            end else begin
               sub_in = sub_ff + 3'd1;
            end
         end
         pic_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = pic_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pic_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `PIC_ASSERT_NEXT(a_accept_scan, state_ff == pic_pkg::ST_IDLE && req_valid, state_ff == pic_pkg::ST_SCAN, "accepted beat did not start a scan")
   `PIC_ASSERT_NOW(a_load_free, cmd.load_rsp, !rsp_valid_ff || rsp_ready, "result loaded over an untaken beat")
   `PIC_ASSERT_NOW(a_sub_range, state_ff == pic_pkg::ST_PHASE, sub_ff <= pic_pkg::SUB_LAST, "phase sub-step out of range")

endmodule

>>> src/palette_indexer_ntsc_composite.sv
// Top level of the palette indexer with NTSC composite DAC sample generation.
// Result timing: a color found in the palette returns once the scan reaches its entry; a new color
//   returns after the full scan and the YIQ and phase micro-ops, and a full one after the full scan.
// Throughput: one pixel at a time, bounded by the one-entry-per-cycle palette scan
//   through the RAM read port plus 29 steps of the shared multiply-accumulate.
// Reset: entry count cleared, black_dac = 70, max_dac = 255; palette RAM is not swept.
module palette_indexer_ntsc_composite #(
   parameter int PALETTE_ENTRIES = 254
) (
   input  logic                              clock,
   input  logic                              reset,
   // pixel beats
   input  logic                              req_valid,
   output logic                              req_ready,
   input  pic_pkg::req_payload_type          req_payload,
   // result beats
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pic_pkg::rsp_payload_type          rsp_payload,
   // configuration writes
   input  logic                              csr_wr_en,
   input  logic [pic_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [7:0]                        csr_wr_data
);

   // DAC level registers; the user writes them only while no beat is in flight (not enforced here)
   logic [7:0] black_dac_ff, black_dac_in;
   logic [7:0] max_dac_ff, max_dac_in;

   pic_pkg::dp_cmd_type    cmd;
   pic_pkg::dp_status_type status;

   always_comb begin
      black_dac_in = black_dac_ff;
      max_dac_in   = max_dac_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            pic_pkg::CSR_BLACK_DAC: black_dac_in = csr_wr_data;
            pic_pkg::CSR_MAX_DAC:   max_dac_in   = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         black_dac_ff <= pic_pkg::BLACK_DAC_RESET;
         max_dac_ff   <= pic_pkg::MAX_DAC_RESET;
      end else begin
         black_dac_ff <= black_dac_in;
         max_dac_ff   <= max_dac_in;
      end
   end

   // Controller: accept, scan, compute sequence, output register handoff.
   // A finished result sits in the output register while the next pixel is taken.
   pic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath: palette RAM, entry count, Q14 MAC, result register.
   pic_dp #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .black_dac   (black_dac_ff),
      .max_dac     (max_dac_ff),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> tb/sv/palette_indexer_ntsc_composite_test.sv
// Self-checking testbench for the NTSC composite palette indexer.
module palette_indexer_ntsc_composite_test;

   localparam int HALF_PERIOD     = 10;
   localparam int PALETTE_ENTRIES = 254;
   localparam int STALL_LIMIT     = 4000;   // cycles with no beat on either channel
   localparam int HOLD_CYCLES     = 400;    // long receiver hold-off
   localparam int HOLD_AT [2]     = '{150, 900};
   localparam int PHASE_PIXELS    = 140;

   // Q14 NTSC weights and the 33 degree subcarrier phase
   localparam longint UNITY     = 16384;
   localparam longint Y_FROM_R  = 4915;
   localparam longint Y_FROM_G  = 9667;
   localparam longint Y_FROM_B  = 1802;
   localparam longint I_FROM_DB = -4424;
   localparam longint I_FROM_DR = 12124;
   localparam longint Q_FROM_DB = 6717;
   localparam longint Q_FROM_DR = 7864;
   localparam longint SIN33     = 8923;
   localparam longint COS33     = 13741;

   // {rgb, first_pixel}: primaries, repeats, odd codes, and clears mid-stream
   localparam logic [24:0] DIRECTED_PIXELS [20] = '{
      {24'h000000, 1'b1}, {24'hFFFFFF, 1'b0}, {24'hFF0000, 1'b0}, {24'h00FF00, 1'b0},
      {24'h0000FF, 1'b0}, {24'hFFFF00, 1'b0}, {24'h00FFFF, 1'b0}, {24'hFF00FF, 1'b0},
      {24'h000000, 1'b0}, {24'hFFFFFF, 1'b0}, {24'hFF00FF, 1'b0}, {24'h010203, 1'b0},
      {24'hFEFDFC, 1'b0}, {24'h807F80, 1'b0}, {24'h7F807F, 1'b0}, {24'hFF00FF, 1'b0},
      {24'hFFFFFF, 1'b1}, {24'hFFFFFF, 1'b1}, {24'h000000, 1'b0}, {24'hFFFFFF, 1'b0}
   };

   typedef enum {IMG_SMALL, IMG_FILL, IMG_NOISE} image_kind_type;

   // Palette model plus the queue of results still owed by the block.
   class palette_scoreboard;
      logic [23:0]              colors [PALETTE_ENTRIES];
      int unsigned              stored;
      logic [7:0]               black_level;
      logic [7:0]               peak_level;
      pic_pkg::rsp_payload_type pending_results [$];
      int unsigned              mismatches;

      function new();
         stored      = 0;
         black_level = pic_pkg::BLACK_DAC_RESET;
         peak_level  = pic_pkg::MAX_DAC_RESET;
         mismatches  = 0;
      endfunction

      function void write_reg(logic [pic_pkg::CSR_IDX_W-1:0] idx, logic [7:0] value);
         case (idx)
            pic_pkg::CSR_BLACK_DAC: black_level = value;
            pic_pkg::CSR_MAX_DAC:   peak_level  = value;
            default: ;
         endcase
      endfunction

      // floor(x / 2^14 + 1/2)
      static function longint round_q14(longint x);
         return (x + 64'sd8192) >>> 14;
      endfunction

      function logic [7:0] dac_code(longint luma, longint inph, longint quad,
                                    longint sn, longint cs);
         longint s;
         longint t;
         s = luma + round_q14(quad * sn + inph * cs);
         if (s < -UNITY) s = -UNITY;
         if (s > UNITY)  s = UNITY;
         // negative scale when max sits below black is used as is
         t = longint'(black_level) * UNITY
             + s * (longint'(peak_level) - longint'(black_level));
         if (t < 0) return 8'd0;
         t = t / UNITY;
         if (t > 255) t = 255;
         return t[7:0];
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction

      // Accepted pixel: look up / append and queue the result it owes.
      function void note_pixel(pic_pkg::req_payload_type px);
         logic [23:0]              rgb;
         pic_pkg::rsp_payload_type want;
         longint                   rq, gq, bq, luma, dr, db, inph, quad;
         rgb  = {px.red, px.green, px.blue};
         want = '0;
         if (px.first_pixel) stored = 0;
         for (int unsigned c = 0; c < stored; c++) begin
            if (colors[c] == rgb) begin
               want.index = 8'(c);
               pending_results.push_back(want);
               return;
            end
         end
         if (stored >= PALETTE_ENTRIES) begin
            want.full_error = 1'b1;
            pending_results.push_back(want);
            return;
         end
         colors[stored] = rgb;
         want.index     = 8'(stored);
         want.is_new    = 1'b1;
         stored++;

         rq   = (longint'(px.red)   * 32768 + 255) / 510;
         gq   = (longint'(px.green) * 32768 + 255) / 510;
         bq   = (longint'(px.blue)  * 32768 + 255) / 510;
         luma = round_q14(Y_FROM_R * rq + Y_FROM_G * gq + Y_FROM_B * bq);
         dr   = rq - luma;
         db   = bq - luma;
         inph = round_q14(I_FROM_DB * db + I_FROM_DR * dr);
         quad = round_q14(Q_FROM_DB * db + Q_FROM_DR * dr);

         want.sample0 = dac_code(luma, inph, quad, SIN33, COS33);
         want.sample1 = dac_code(luma, inph, quad, COS33, -SIN33);
         want.sample2 = dac_code(luma, inph, quad, -SIN33, -COS33);
         want.sample3 = dac_code(luma, inph, quad, -COS33, SIN33);
         pending_results.push_back(want);
      endfunction

      static function string describe(pic_pkg::rsp_payload_type r);
         return $sformatf("index %0d new %0b full %0b samples %0d/%0d/%0d/%0d",
                          r.index, r.is_new, r.full_error,
                          r.sample0, r.sample1, r.sample2, r.sample3);
      endfunction

      function void check_result(pic_pkg::rsp_payload_type got);
         pic_pkg::rsp_payload_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat: %s", describe(got));
            return;
         end
         want = pending_results.pop_front();
         if (got.index !== want.index || got.is_new !== want.is_new
             || got.full_error !== want.full_error
             || got.sample0 !== want.sample0 || got.sample1 !== want.sample1
             || got.sample2 !== want.sample2 || got.sample3 !== want.sample3) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: expected %s, got %s",
                        describe(want), describe(got));
         end
      endfunction
   endclass

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_ready;
   pic_pkg::req_payload_type      req_payload = '0;
   logic                          rsp_valid;
   logic                          rsp_ready   = 1'b0;
   pic_pkg::rsp_payload_type      rsp_payload;
   logic                          csr_wr_en   = 1'b0;
   logic [pic_pkg::CSR_IDX_W-1:0] csr_index   = '0;
   logic [7:0]                    csr_wr_data = '0;

   palette_scoreboard model = new();
   int pixels_sent  = 0;
   int results_seen = 0;
   int quiet_cycles = 0;

   palette_indexer_ntsc_composite #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Handshakes are sampled at the falling edge, where everything is settled;
   // a beat seen there completes at the following rising edge.
   task automatic send_pixel(input logic [23:0] rgb, input logic first);
      pic_pkg::req_payload_type px;
      px.red         = rgb[23:16];
      px.green       = rgb[15:8];
      px.blue        = rgb[7:0];
      px.first_pixel = first;
      // random idle cycles, except in the no-gap stretch
      while (!(pixels_sent >= 600 && pixels_sent < 900) && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= px;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      model.note_pixel(px);
      pixels_sent++;
   endtask

   // Stop offering pixels until every owed result is back; block is then idle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (model.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Caller lowers csr_wr_en after the last write.
   task automatic write_csr(input logic [pic_pkg::CSR_IDX_W-1:0] idx,
                            input logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      model.write_reg(idx, value);
   endtask

   // One image: pixels shaped by the image kind; small and fill images start with a clear.
   //   small: few colors, mostly repeats -> shallow hits and appends
   //   fill:  mostly fresh colors -> fills the palette, then full errors and deep hits
   //   noise: random colors and random clears
   task automatic run_image(input image_kind_type kind);
      logic [23:0] color_pool [$];
      logic [23:0] rgb;
      logic        first;
      int          len;
      case (kind)
         IMG_FILL:  len = $urandom_range(330, 300);
         IMG_NOISE: len = $urandom_range(20, 1);
         default: begin
            len = $urandom_range(40, 1);
            repeat ($urandom_range(12, 1)) color_pool.push_back(24'($urandom));
         end
      endcase
      for (int k = 0; k < len; k++) begin
         rgb   = 24'($urandom);
         first = (k == 0) || ($urandom_range(199) == 0);
         case (kind)
            IMG_NOISE: first = 1'($urandom);
            IMG_FILL: begin
               if (color_pool.size() > 0 && $urandom_range(99) < 10)
                  rgb = color_pool[$urandom_range(color_pool.size() - 1)];
               else
                  color_pool.push_back(rgb);
            end
            default: begin
               if ($urandom_range(9) != 0)
                  rgb = color_pool[$urandom_range(color_pool.size() - 1)];
            end
         endcase
         send_pixel(rgb, first);
      end
   endtask

   // Pixel source: directed pixels, then phases of random images, one DAC setting each.
   initial begin : pixel_source
      logic [7:0]     black;
      logic [7:0]     peak;
      int             phase_end;
      int             pick;
      image_kind_type kind;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_PIXELS[n])
         send_pixel(DIRECTED_PIXELS[n][24:1], DIRECTED_PIXELS[n][0]);

      for (int ph = 0; ph < 8; ph++) begin
         drain_results();
         case (ph)
            0: begin black = 8'd70;  peak = 8'd255; end
            1: begin black = 8'd0;   peak = 8'd255; end
            2: begin black = 8'd255; peak = 8'd0;   end   // max below black
            3: begin black = 8'd0;   peak = 8'd0;   end
            4: begin black = 8'd255; peak = 8'd255; end
            5: begin black = 8'd200; peak = 8'd30;  end
            default: begin
               black = 8'($urandom);
               peak  = 8'($urandom);
            end
         endcase
         write_csr(pic_pkg::CSR_BLACK_DAC, black);
         write_csr(pic_pkg::CSR_MAX_DAC, peak);
         csr_wr_en <= 1'b0;

         phase_end = pixels_sent + PHASE_PIXELS;
         if (ph == 0 || ph == 2) run_image(IMG_FILL);
         while (pixels_sent < phase_end) begin
            pick = $urandom_range(99);
            if (pick < 3)       kind = IMG_FILL;
            else if (pick < 12) kind = IMG_NOISE;
            else                kind = IMG_SMALL;
            run_image(kind);
         end
      end

      drain_results();
      // stray beats after the last expected one would show up here
      repeat (300) @(posedge clock);
      if (model.mismatches == 0 && model.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Result sink: random ready with a no-stall stretch and two long hold-offs
   // that back the block up into the pixel channel.
   initial begin : result_sink
      pic_pkg::rsp_payload_type beat;
      logic                     fire;
      int                       hold_left;
      int                       holds_done;
      hold_left  = 0;
      holds_done = 0;
      while (reset) @(posedge clock);
      forever begin
         @(negedge clock);
         fire = rsp_valid && rsp_ready;
         beat = rsp_payload;
         @(posedge clock);
         if (fire) begin
            model.check_result(beat);
            results_seen++;
         end
         if (hold_left == 0 && holds_done < 2 && results_seen >= HOLD_AT[holds_done]) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (results_seen >= 600 && results_seen < 900)
                         || ($urandom_range(99) >= 7);
         end
      end
   end

   // Watchdog: too long with no beat on either channel means the block hung.
   always @(negedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule

>>> files.f
+incdir+src
src/pic_pkg.sv
src/pic_ram.sv
src/pic_dp.sv
src/pic_ctrl.sv
src/palette_indexer_ntsc_composite.sv
tb/sv/palette_indexer_ntsc_composite_test.sv
